### hw/rtl/lfps_pkg.sv
package lfps_pkg;

  localparam int ERR_W   = 3;
  localparam int GAIN_W  = 8;
  localparam int LIMIT_W = 10;
  localparam int SPEED_W = 8;
  localparam int TIME_W  = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED  = 3'd4;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 8'd10;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 8'd0;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 8'd0;
  localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 10'd10;
  localparam logic [SPEED_W-1:0] BASE_SPEED_RST  = 8'd45;

  // The error difference spans -6 to 6, so its magnitude times the gain and
  // the derivative scale bounds both the numerator and the quotient.
  localparam int DIFF_MAX = 6;
  localparam int DSCALE_W = 10;
  localparam logic [DSCALE_W-1:0] DSCALE = 10'd1000;
  localparam int DPROD_W = $clog2(DIFF_MAX * 255 + 1);
  localparam int MAG_W   = $clog2(DIFF_MAX * 255 * 1000 + 1);
  localparam int NUM_W   = TIME_W + 2;
  localparam int DEN_W   = TIME_W + 1;
  localparam int QUO_W   = MAG_W;
  localparam int DTERM_W = MAG_W + 1;
  localparam int PTERM_W = ERR_W + GAIN_W + 1;
  localparam int ITERM_W = LIMIT_W + 1;
  localparam int ADJ_W   = DTERM_W + 2;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DECODE,
    OP_UPDATE,
    OP_PRODUCTS,
    OP_SCALE,
    OP_DIV_LOAD,
    OP_ADJUST,
    OP_EMIT,
    OP_EMIT_LOST
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_LOST,
    COND_DT_ZERO,
    COND_DIV_DONE,
    COND_OUT_FREE
  } cond_t;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] STEP_WAIT      = 4'd0;
  localparam logic [PC_W-1:0] STEP_DECODE    = 4'd1;
  localparam logic [PC_W-1:0] STEP_UPDATE    = 4'd2;
  localparam logic [PC_W-1:0] STEP_PRODUCTS  = 4'd3;
  localparam logic [PC_W-1:0] STEP_SCALE     = 4'd4;
  localparam logic [PC_W-1:0] STEP_DIV_LOAD  = 4'd5;
  localparam logic [PC_W-1:0] STEP_DIV_WAIT  = 4'd6;
  localparam logic [PC_W-1:0] STEP_ADJUST    = 4'd7;
  localparam logic [PC_W-1:0] STEP_EMIT      = 4'd8;
  localparam logic [PC_W-1:0] STEP_EMIT_LOST = 4'd9;

  // When cond holds the step jumps to target; otherwise it stays put if hold
  // is set and moves to the next step if not.
  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic            hold;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      STEP_WAIT:      w = '{OP_ACCEPT,    COND_IN_VALID, 1'b1, STEP_DECODE};
      STEP_DECODE:    w = '{OP_DECODE,    COND_LOST,     1'b0, STEP_EMIT_LOST};
      STEP_UPDATE:    w = '{OP_UPDATE,    COND_ALWAYS,   1'b0, STEP_PRODUCTS};
      STEP_PRODUCTS:  w = '{OP_PRODUCTS,  COND_ALWAYS,   1'b0, STEP_SCALE};
      STEP_SCALE:     w = '{OP_SCALE,     COND_ALWAYS,   1'b0, STEP_DIV_LOAD};
      STEP_DIV_LOAD:  w = '{OP_DIV_LOAD,  COND_DT_ZERO,  1'b0, STEP_ADJUST};
      STEP_DIV_WAIT:  w = '{OP_NOP,       COND_DIV_DONE, 1'b1, STEP_ADJUST};
      STEP_ADJUST:    w = '{OP_ADJUST,    COND_ALWAYS,   1'b0, STEP_EMIT};
      STEP_EMIT:      w = '{OP_EMIT,      COND_OUT_FREE, 1'b1, STEP_WAIT};
      STEP_EMIT_LOST: w = '{OP_EMIT_LOST, COND_OUT_FREE, 1'b1, STEP_WAIT};
      default:        w = '{OP_NOP,       COND_ALWAYS,   1'b0, STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/line_follow_pid_steering.sv
// Each accepted beat is decoded, folded into the tracking state, then run through
// products, scaling, the 21-step derivative divider, adjustment and emission; the
// divider is skipped when no time has passed since the change before last, and an
// indeterminate pattern goes straight to emission. A new beat is taken only once the
// last is emitted, but while the previous result waits; the divider dominates.
// Reset: synchronous, clears all tracking state and loads the register defaults.
module line_follow_pid_steering #(
  parameter int SUM_BITS  = 24,
  parameter int DRIVE_MAX = 255,
  localparam int DRIVE_W  = $clog2(DRIVE_MAX + 1) + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                left_sensor,
  input  logic                                centre_sensor,
  input  logic                                right_sensor,
  input  logic [lfps_pkg::TIME_W-1:0]         now_us,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [DRIVE_W-1:0]           left_drive,
  output logic signed [DRIVE_W-1:0]           right_drive,
  output logic signed [lfps_pkg::ERR_W-1:0]   line_error,
  output logic                                line_lost
);

  localparam int ERR_W  = lfps_pkg::ERR_W;
  localparam int ADJ_W  = lfps_pkg::ADJ_W;
  localparam int PROD_W = SUM_BITS + lfps_pkg::GAIN_W + 1;
  localparam logic signed [ADJ_W:0] DMAX = (ADJ_W + 1)'(DRIVE_MAX);
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS - 1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS - 1){1'b0}}};

  logic [lfps_pkg::GAIN_W-1:0]  prop_gain;
  logic [lfps_pkg::GAIN_W-1:0]  integ_gain;
  logic [lfps_pkg::GAIN_W-1:0]  deriv_gain;
  logic [lfps_pkg::LIMIT_W-1:0] integ_limit;
  logic [lfps_pkg::SPEED_W-1:0] base_speed;

  logic [lfps_pkg::PC_W-1:0]    pc;
  logic [lfps_pkg::PC_W-1:0]    pc_next;
  lfps_pkg::uword_t             uw;
  logic                         cond_true;

  logic [2:0]                   sens;
  logic [lfps_pkg::TIME_W-1:0]  now_r;
  logic signed [ERR_W-1:0]      err;
  logic signed [ERR_W-1:0]      err_c;
  logic                         lost_c;

  logic signed [ERR_W-1:0]      prev_error;
  logic signed [ERR_W-1:0]      prior_distinct_error;
  logic [lfps_pkg::TIME_W-1:0]  change_time;
  logic [lfps_pkg::TIME_W-1:0]  earlier_change_time;
  logic signed [SUM_BITS-1:0]   error_sum;
  logic signed [SUM_BITS:0]     sum_wide;
  logic signed [SUM_BITS-1:0]   sum_sat;

  logic signed [ERR_W:0]        diff;
  logic [ERR_W:0]               diff_abs;
  logic signed [PROD_W-1:0]     ip_prod;
  logic signed [PROD_W-1:0]     lim_pos;
  logic signed [PROD_W-1:0]     lim_neg;
  logic [lfps_pkg::DPROD_W-1:0] dprod;
  logic                         dneg;
  logic [lfps_pkg::TIME_W-1:0]  dt;
  logic                         dt_zero;
  logic signed [lfps_pkg::PTERM_W-1:0] pterm;
  logic signed [lfps_pkg::ITERM_W-1:0] iterm;
  logic [lfps_pkg::MAG_W-1:0]   mag;
  logic signed [lfps_pkg::DTERM_W-1:0] dterm;
  logic signed [ADJ_W-1:0]      adj;
  logic signed [ADJ_W:0]        base_s;
  logic signed [ADJ_W:0]        left_sum;
  logic signed [ADJ_W:0]        right_sum;

  logic                         out_free;
  logic                         emit;
  lfps_pkg::div_req_t           div_req;
  lfps_pkg::div_rsp_t           div_rsp;

  function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [ADJ_W:0] v);
    logic signed [ADJ_W:0] r;
    if (v > DMAX) begin
      r = DMAX;
    end else if (v < -DMAX) begin
      r = -DMAX;
    end else begin
      r = v;
    end
    return DRIVE_W'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= lfps_pkg::PROP_GAIN_RST;
      integ_gain  <= lfps_pkg::INTEG_GAIN_RST;
      deriv_gain  <= lfps_pkg::DERIV_GAIN_RST;
      integ_limit <= lfps_pkg::INTEG_LIMIT_RST;
      base_speed  <= lfps_pkg::BASE_SPEED_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        lfps_pkg::CFG_PROP_GAIN:   prop_gain   <= cfg_data[lfps_pkg::GAIN_W-1:0];
        lfps_pkg::CFG_INTEG_GAIN:  integ_gain  <= cfg_data[lfps_pkg::GAIN_W-1:0];
        lfps_pkg::CFG_DERIV_GAIN:  deriv_gain  <= cfg_data[lfps_pkg::GAIN_W-1:0];
        lfps_pkg::CFG_INTEG_LIMIT: integ_limit <= cfg_data[lfps_pkg::LIMIT_W-1:0];
        lfps_pkg::CFG_BASE_SPEED:  base_speed  <= cfg_data[lfps_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign uw       = lfps_pkg::ucode(pc);
  assign in_ready = uw.op == lfps_pkg::OP_ACCEPT;
  assign out_free = !out_valid || out_ready;
  assign dt_zero  = dt == '0;

  always_comb begin
    unique case (uw.cond)
      lfps_pkg::COND_ALWAYS:   cond_true = 1'b1;
      lfps_pkg::COND_IN_VALID: cond_true = in_valid;
      lfps_pkg::COND_LOST:     cond_true = lost_c;
      lfps_pkg::COND_DT_ZERO:  cond_true = dt_zero;
      lfps_pkg::COND_DIV_DONE: cond_true = div_rsp.done;
      lfps_pkg::COND_OUT_FREE: cond_true = out_free;
      default:                 cond_true = 1'b1;
    endcase
    if (cond_true) begin
      pc_next = uw.target;
    end else if (uw.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + lfps_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= lfps_pkg::STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    lost_c = 1'b0;
    err_c  = '0;
    case (sens)
      3'b010: err_c = ERR_W'(0);
      3'b110: err_c = ERR_W'(-1);
      3'b100: err_c = ERR_W'(-2);
      3'b011: err_c = ERR_W'(1);
      3'b001: err_c = ERR_W'(2);
      3'b000: begin
        if (prev_error > 0) begin
          err_c = ERR_W'(3);
        end else if (prev_error < 0) begin
          err_c = ERR_W'(-3);
        end else begin
          lost_c = 1'b1;
        end
      end
      default: lost_c = 1'b1;
    endcase
  end

  always_comb begin
    sum_wide = (SUM_BITS + 1)'(error_sum) + (SUM_BITS + 1)'(err);
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_sat = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_BITS-1:0];
    end
    diff     = (ERR_W + 1)'(err) - (ERR_W + 1)'(prior_distinct_error);
    diff_abs = diff[ERR_W] ? -diff : diff;
    lim_pos  = PROD_W'($signed({1'b0, integ_limit}));
    lim_neg  = -lim_pos;
    dterm    = dneg ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
    if (dt_zero) begin
      dterm = '0;
    end
    base_s    = (ADJ_W + 1)'($signed({1'b0, base_speed}));
    left_sum  = base_s + (ADJ_W + 1)'(adj);
    right_sum = base_s - (ADJ_W + 1)'(adj);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error           <= '0;
      prior_distinct_error <= '0;
      change_time          <= '0;
      earlier_change_time  <= '0;
      error_sum            <= '0;
    end else if (uw.op == lfps_pkg::OP_UPDATE) begin
      if (err != prev_error) begin
        earlier_change_time  <= change_time;
        change_time          <= now_r;
        prior_distinct_error <= prev_error;
      end
      error_sum  <= sum_sat;
      prev_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      lfps_pkg::OP_ACCEPT: begin
        if (in_valid) begin
          sens  <= {left_sensor, centre_sensor, right_sensor};
          now_r <= now_us;
        end
      end
      lfps_pkg::OP_DECODE: begin
        err <= err_c;
      end
      lfps_pkg::OP_PRODUCTS: begin
        ip_prod <= PROD_W'(error_sum) * PROD_W'($signed({1'b0, integ_gain}));
        dprod   <= lfps_pkg::DPROD_W'(diff_abs) * lfps_pkg::DPROD_W'(deriv_gain);
        dneg    <= diff[ERR_W];
        dt      <= now_r - earlier_change_time;
        pterm   <= lfps_pkg::PTERM_W'(err) *
                   lfps_pkg::PTERM_W'($signed({1'b0, prop_gain}));
      end
      lfps_pkg::OP_SCALE: begin
        mag <= lfps_pkg::MAG_W'(dprod) * lfps_pkg::MAG_W'(lfps_pkg::DSCALE);
        if (ip_prod > lim_pos) begin
          iterm <= lfps_pkg::ITERM_W'(lim_pos);
        end else if (ip_prod < lim_neg) begin
          iterm <= lfps_pkg::ITERM_W'(lim_neg);
        end else begin
          iterm <= lfps_pkg::ITERM_W'(ip_prod);
        end
      end
      lfps_pkg::OP_ADJUST: begin
        adj <= ADJ_W'(pterm) + ADJ_W'(iterm) + ADJ_W'(dterm);
      end
      default: ;
    endcase
  end

  assign div_req.start = (uw.op == lfps_pkg::OP_DIV_LOAD) && !dt_zero;
  assign div_req.numer = lfps_pkg::NUM_W'({mag, 1'b0}) + lfps_pkg::NUM_W'(dt);
  assign div_req.denom = {dt, 1'b0};

  lfps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign emit = out_free &&
                ((uw.op == lfps_pkg::OP_EMIT) || (uw.op == lfps_pkg::OP_EMIT_LOST));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (uw.op == lfps_pkg::OP_EMIT_LOST) begin
        left_drive  <= sat_drive(base_s);
        right_drive <= sat_drive(base_s);
        line_error  <= '0;
        line_lost   <= 1'b1;
      end else begin
        left_drive  <= sat_drive(left_sum);
        right_drive <= sat_drive(right_sum);
        line_error  <= err;
        line_lost   <= 1'b0;
      end
    end
  end

  a_div_idle_on_accept: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> div_rsp.done)
    else $error("Divider still running when a new beat can be taken.");

  a_accept_to_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (pc == lfps_pkg::STEP_DECODE))
    else $error("Accepted beat did not move the sequencer to decode.");

  a_lost_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_lost) |-> ((left_drive == right_drive) && (line_error == '0)))
    else $error("Indeterminate result carries a steering correction.");

  a_prev_error_range: assert property (@(posedge clk) disable iff (rst)
    prev_error != ERR_W'(-4))
    else $error("Stored line error left its range.");

  a_iterm_clamped: assert property (@(posedge clk) disable iff (rst)
    (uw.op == lfps_pkg::OP_ADJUST) |->
      ((PROD_W'(iterm) <= lim_pos) && (PROD_W'(iterm) >= lim_neg)))
    else $error("Integral term exceeds its limit.");

endmodule

### hw/rtl/lfps_div.sv
module lfps_div (
  input  logic              clk,
  input  logic              rst,
  input  lfps_pkg::div_req_t req,
  output lfps_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(lfps_pkg::QUO_W + 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [lfps_pkg::DEN_W-1:0]    rem;
  logic [lfps_pkg::DEN_W-1:0]    denom;
  logic [lfps_pkg::QUO_W-1:0]    low;
  logic [lfps_pkg::DEN_W:0]      trial;
  logic                          fits;

  // The quotient is known to fit in QUO_W bits, so the upper numerator bits
  // start out as the partial remainder and only QUO_W steps remain.
  assign trial = {rem, low[lfps_pkg::QUO_W-1]};
  assign fits  = trial >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(lfps_pkg::QUO_W);
    end else if (busy) begin
      cnt  <= cnt - CNT_W'(1);
      busy <= cnt != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= lfps_pkg::DEN_W'(req.numer[lfps_pkg::NUM_W-1:lfps_pkg::QUO_W]);
      low   <= req.numer[lfps_pkg::QUO_W-1:0];
      denom <= req.denom;
    end else if (busy) begin
      if (fits) begin
        rem <= lfps_pkg::DEN_W'(trial - {1'b0, denom});
      end else begin
        rem <= trial[lfps_pkg::DEN_W-1:0];
      end
      low <= {low[lfps_pkg::QUO_W-2:0], fits};
    end
  end

  assign rsp.done = !busy;
  assign rsp.quot = low;

  a_rem_below_denom: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < denom))
    else $error("Divider remainder reached the divisor.");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0))
    else $error("Divider busy with an empty step count.");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("Divider started while a division was running.");

endmodule
